[rtl/core/stpc_pkg.sv]
// Shared constants and a helper function for the stepper position controller.
package stpc_pkg;

  localparam int STEP_COUNT_BITS = 18;

  localparam int TS_W   = 17;
  localparam int SP_W   = 16;
  localparam int MT_W   = 26;
  localparam int PP_W   = 24;
  localparam int CMD_W  = 3;
  localparam int PIN_W  = 8;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;

  // step_count * 100 fits in the magnitude bits plus seven
  localparam int DVD_W  = STEP_COUNT_BITS - 1 + 7;

  localparam logic signed [STEP_COUNT_BITS-1:0] SC_MAX = {1'b0, {(STEP_COUNT_BITS-1){1'b1}}};
  localparam logic signed [STEP_COUNT_BITS-1:0] SC_MIN = {1'b1, {(STEP_COUNT_BITS-1){1'b0}}};
  localparam logic signed [STEP_COUNT_BITS-1:0] SC_ONE = STEP_COUNT_BITS'(1);

  localparam logic [POS_W-1:0] POS_FULL = POS_W'(100);
  localparam logic [POS_W-1:0] POS_HIGH = POS_W'(99);
  localparam logic [POS_W-1:0] POS_LOW  = POS_W'(1);

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

  localparam logic [STAT_W-1:0] ST_CLOSED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_OPENED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_STOPPED = 2'd2;
  localparam logic [STAT_W-1:0] ST_MOVING  = 2'd3;

  localparam logic [1:0] REG_TOTAL_STEPS    = 2'd0;
  localparam logic [1:0] REG_STEP_PERIOD    = 2'd1;
  localparam logic [1:0] REG_MOVE_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_PUBLISH_PERIOD = 2'd3;

  localparam logic [TS_W-1:0] TS_RST = TS_W'(10000);
  localparam logic [SP_W-1:0] SP_RST = SP_W'(200);
  localparam logic [MT_W-1:0] MT_RST = MT_W'(30000000);
  localparam logic [PP_W-1:0] PP_RST = PP_W'(500000);

  function automatic logic [STAT_W-1:0] classify(input logic [POS_W-1:0] pos);
    logic [STAT_W-1:0] st;
    if (pos >= POS_HIGH) st = ST_OPENED;
    else if (pos <= POS_LOW) st = ST_CLOSED;
    else st = ST_STOPPED;
    return st;
  endfunction

endpackage

[rtl/core/stepper_target_position_control.sv]
// Stepper position controller top level: command sequencer, state and config registers.
//
// Usage: one command per input transaction on s_axis (tdata[2:0] command,
// tdata[10:3] percent). Commands: tick, set position, open, close, stop.
// Every transaction yields exactly one result transaction on m_axis.
// Sequence: an accepted command moves from S_IDLE to S_OUT, where its result
// is loaded into the output register once that register is free, and then
// returns to S_IDLE. A tick that issues a step first runs the serial divider
// for the percentage in S_DIV (one quotient bit at a time), which updates the
// position, then checks the target in S_FIN before S_OUT. With total_steps at
// zero the divider is skipped and the tick goes straight to S_FIN.
// One command is in flight at a time and s_axis_tready is low meanwhile.
// The output register lets the next command be accepted while a result waits;
// a stalled receiver holds the result and, once another result is ready,
// holds the sequencer until the register frees up.
// Config over APB: total_steps 0x0, step_period 0x4, move_timeout 0x8,
// publish_period 0xC; write only while no command is in flight.
// Reset: step count, position, timers cleared, target none, direction
// opening, status closed, config at defaults, no result pending.
module stepper_target_position_control (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] command, [10:3] percent
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] step_pulse, [1] dir_open, [2] motor_enable,
                                      // [9:3] position, [11:10] status,
                                      // [12] save_request, [13] publish
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N = stpc_pkg::STEP_COUNT_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [stpc_pkg::TS_W-1:0] total_steps_q;
  logic [stpc_pkg::SP_W-1:0] step_period_q;
  logic [stpc_pkg::MT_W-1:0] move_timeout_q;
  logic [stpc_pkg::PP_W-1:0] publish_period_q;

  logic signed [N-1:0]          step_count_q, step_count_d;
  logic [stpc_pkg::POS_W-1:0]   position_q, position_d;
  logic [stpc_pkg::POS_W-1:0]   target_q, target_d;
  logic                         target_valid_q, target_valid_d;
  logic                         moving_q, moving_d;
  logic                         dir_q, dir_d;
  logic [stpc_pkg::STAT_W-1:0]  status_q, status_d;
  logic [stpc_pkg::MT_W-1:0]    move_timer_q, move_timer_d;
  logic [stpc_pkg::SP_W-1:0]    step_timer_q, step_timer_d;
  logic [stpc_pkg::PP_W-1:0]    pub_timer_q, pub_timer_d;
  logic                         pulse_q, pulse_d;
  logic                         save_q, save_d;
  logic                         pub_q, pub_d;

  logic        m_valid_q;
  logic [15:0] m_data_q;
  logic        out_load;

  logic                          div_start;
  logic [stpc_pkg::DVD_W-1:0]    div_dividend;
  logic                          div_done;
  logic [stpc_pkg::DVD_W-1:0]    div_quotient;

  logic [stpc_pkg::CMD_W-1:0]    cmd;
  logic [stpc_pkg::PIN_W-1:0]    pct_in;
  logic [stpc_pkg::POS_W-1:0]    pct_c;
  logic [stpc_pkg::MT_W-1:0]     mt_inc;
  logic [stpc_pkg::SP_W-1:0]     st_inc;
  logic [stpc_pkg::PP_W-1:0]     pt_inc;
  logic signed [N-1:0]           sc_next;
  logic [stpc_pkg::DVD_W-1:0]    sc_ext;
  logic                          open_ok;
  logic                          close_ok;
  logic                          reached;
  logic                          cfg_wr;

  assign cmd    = s_axis_tdata[2:0];
  assign pct_in = s_axis_tdata[10:3];
  assign pct_c  = (pct_in > stpc_pkg::PIN_W'(100)) ? stpc_pkg::POS_FULL
                                                  : pct_in[stpc_pkg::POS_W-1:0];

  assign mt_inc = (move_timer_q == '1) ? move_timer_q : move_timer_q + stpc_pkg::MT_W'(1);
  assign st_inc = (step_timer_q == '1) ? step_timer_q : step_timer_q + stpc_pkg::SP_W'(1);
  assign pt_inc = (pub_timer_q == '1)  ? pub_timer_q  : pub_timer_q + stpc_pkg::PP_W'(1);

  always_comb begin
    sc_next = step_count_q;
    if (dir_q) begin
      if (step_count_q != stpc_pkg::SC_MAX) sc_next = step_count_q + stpc_pkg::SC_ONE;
    end else begin
      if (step_count_q != stpc_pkg::SC_MIN) sc_next = step_count_q - stpc_pkg::SC_ONE;
    end
  end

  // x*100 = x*64 + x*32 + x*4; negative counts clamp to zero
  assign sc_ext       = stpc_pkg::DVD_W'(sc_next[N-2:0]);
  assign div_dividend = sc_next[N-1] ? '0 : (sc_ext << 6) + (sc_ext << 5) + (sc_ext << 2);

  assign open_ok  = (status_q != stpc_pkg::ST_OPENED) && (status_q != stpc_pkg::ST_MOVING);
  assign close_ok = (status_q != stpc_pkg::ST_CLOSED) && (status_q != stpc_pkg::ST_MOVING);
  assign reached  = target_valid_q && ((dir_q && (position_q >= target_q)) ||
                                       (!dir_q && (position_q <= target_q)));

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d        = state_q;
    step_count_d   = step_count_q;
    position_d     = position_q;
    target_d       = target_q;
    target_valid_d = target_valid_q;
    moving_d       = moving_q;
    dir_d          = dir_q;
    status_d       = status_q;
    move_timer_d   = move_timer_q;
    step_timer_d   = step_timer_q;
    pub_timer_d    = pub_timer_q;
    pulse_d        = pulse_q;
    save_d         = save_q;
    pub_d          = pub_q;
    div_start      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          pulse_d = 1'b0;
          save_d  = 1'b0;
          pub_d   = 1'b0;
          state_d = S_OUT;
          case (cmd)
            stpc_pkg::CMD_TICK: begin
              if (moving_q) begin
                move_timer_d = mt_inc;
                step_timer_d = st_inc;
                pub_timer_d  = pt_inc;
                if (mt_inc >= move_timeout_q) begin
                  moving_d       = 1'b0;
                  status_d       = dir_q ? stpc_pkg::ST_OPENED : stpc_pkg::ST_CLOSED;
                  target_valid_d = 1'b0;
                  save_d         = 1'b1;
                  pub_d          = 1'b1;
                end else if (st_inc >= step_period_q) begin
                  step_timer_d = '0;
                  pulse_d      = 1'b1;
                  step_count_d = sc_next;
                  if (pt_inc >= publish_period_q) begin
                    pub_timer_d = '0;
                    pub_d       = 1'b1;
                  end
                  if (total_steps_q != '0) begin
                    div_start = 1'b1;
                    state_d   = S_DIV;
                  end else begin
                    state_d = S_FIN;
                  end
                end
              end
            end
            stpc_pkg::CMD_SET: begin
              if (pct_c != position_q) begin
                target_d       = pct_c;
                target_valid_d = 1'b1;
                if (pct_c > position_q) begin
                  if (open_ok) begin
                    dir_d        = 1'b1;
                    moving_d     = 1'b1;
                    move_timer_d = '0;
                    step_timer_d = '0;
                    pub_timer_d  = '0;
                    status_d     = stpc_pkg::ST_MOVING;
                  end
                end else if (close_ok) begin
                  dir_d        = 1'b0;
                  moving_d     = 1'b1;
                  move_timer_d = '0;
                  step_timer_d = '0;
                  pub_timer_d  = '0;
                  status_d     = stpc_pkg::ST_MOVING;
                end
              end
            end
            stpc_pkg::CMD_OPEN: begin
              if (open_ok) begin
                dir_d        = 1'b1;
                moving_d     = 1'b1;
                move_timer_d = '0;
                step_timer_d = '0;
                pub_timer_d  = '0;
                status_d     = stpc_pkg::ST_MOVING;
              end
            end
            stpc_pkg::CMD_CLOSE: begin
              if (close_ok) begin
                dir_d        = 1'b0;
                moving_d     = 1'b1;
                move_timer_d = '0;
                step_timer_d = '0;
                pub_timer_d  = '0;
                status_d     = stpc_pkg::ST_MOVING;
              end
            end
            stpc_pkg::CMD_STOP: begin
              if (moving_q) begin
                moving_d = 1'b0;
                status_d = stpc_pkg::classify(position_q);
                save_d   = 1'b1;
                pub_d    = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          position_d = (div_quotient > stpc_pkg::DVD_W'(100)) ? stpc_pkg::POS_FULL
                                                             : div_quotient[stpc_pkg::POS_W-1:0];
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        if (reached) begin
          moving_d       = 1'b0;
          status_d       = stpc_pkg::classify(position_q);
          target_valid_d = 1'b0;
          save_d         = 1'b1;
          pub_d          = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  stpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (total_steps_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      step_count_q   <= '0;
      position_q     <= '0;
      target_q       <= '0;
      target_valid_q <= 1'b0;
      moving_q       <= 1'b0;
      dir_q          <= 1'b1;
      status_q       <= stpc_pkg::ST_CLOSED;
      move_timer_q   <= '0;
      step_timer_q   <= '0;
      pub_timer_q    <= '0;
      pulse_q        <= 1'b0;
      save_q         <= 1'b0;
      pub_q          <= 1'b0;
    end else begin
      state_q        <= state_d;
      step_count_q   <= step_count_d;
      position_q     <= position_d;
      target_q       <= target_d;
      target_valid_q <= target_valid_d;
      moving_q       <= moving_d;
      dir_q          <= dir_d;
      status_q       <= status_d;
      move_timer_q   <= move_timer_d;
      step_timer_q   <= step_timer_d;
      pub_timer_q    <= pub_timer_d;
      pulse_q        <= pulse_d;
      save_q         <= save_d;
      pub_q          <= pub_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {2'b00, pub_q, save_q, status_q, position_q, moving_q, dir_q, pulse_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // APB config
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_steps_q    <= stpc_pkg::TS_RST;
      step_period_q    <= stpc_pkg::SP_RST;
      move_timeout_q   <= stpc_pkg::MT_RST;
      publish_period_q <= stpc_pkg::PP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        stpc_pkg::REG_TOTAL_STEPS:    total_steps_q    <= pwdata[stpc_pkg::TS_W-1:0];
        stpc_pkg::REG_STEP_PERIOD:    step_period_q    <= pwdata[stpc_pkg::SP_W-1:0];
        stpc_pkg::REG_MOVE_TIMEOUT:   move_timeout_q   <= pwdata[stpc_pkg::MT_W-1:0];
        stpc_pkg::REG_PUBLISH_PERIOD: publish_period_q <= pwdata[stpc_pkg::PP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      stpc_pkg::REG_TOTAL_STEPS:    prdata = 32'(total_steps_q);
      stpc_pkg::REG_STEP_PERIOD:    prdata = 32'(step_period_q);
      stpc_pkg::REG_MOVE_TIMEOUT:   prdata = 32'(move_timeout_q);
      stpc_pkg::REG_PUBLISH_PERIOD: prdata = 32'(publish_period_q);
      default:                      prdata = '0;
    endcase
  end

endmodule

[rtl/core/stpc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module stpc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [stpc_pkg::DVD_W-1:0]  dividend_i,
  input  logic [stpc_pkg::TS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [stpc_pkg::DVD_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(stpc_pkg::DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(stpc_pkg::DVD_W - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [stpc_pkg::TS_W-1:0]   rem_q, rem_d;
  logic [stpc_pkg::DVD_W-1:0]  quo_q, quo_d;
  logic [stpc_pkg::TS_W:0]     trial;
  logic [stpc_pkg::TS_W:0]     dsr;
  logic                        fits;

  assign trial = {rem_q, quo_q[stpc_pkg::DVD_W-1]};
  assign dsr   = {1'b0, divisor_i};
  assign fits  = (trial >= dsr);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      quo_d = {quo_q[stpc_pkg::DVD_W-2:0], fits};
      if (fits) rem_d = stpc_pkg::TS_W'(trial - dsr);
      else rem_d = trial[stpc_pkg::TS_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/stpc_checker.sv]
// Port-level checker for the stepper position controller, bound to the top level.
module stpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9:3] <= 7'd100)
    else $error("position above 100");

  // enable tracks moving status
  a_enable_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[11:10] == stpc_pkg::ST_MOVING)))
    else $error("motor_enable disagrees with status");

  a_save_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[13] && !m_axis_tdata[2])
    else $error("save without publish or while moving");

endmodule

bind stepper_target_position_control stpc_checker u_stpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
